/* src/coherence_neighbor_match_macros.svh */
// Assertion macros shared by the coherence neighbour match RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef COHERENCE_NEIGHBOR_MATCH_MACROS_SVH
`define COHERENCE_NEIGHBOR_MATCH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CNM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CNM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cnm_pkg.sv */
// Shared types and constants for the coherence neighbour match block.
// Depends on nothing.
package cnm_pkg;

    localparam int SRC_PIXELS     = 4096;
    localparam int DST_PIXELS     = 4096;
    localparam int MAX_COMPONENTS = 8;

    localparam int PIX_W       = 12;
    localparam int COMP_W      = 3;
    localparam int VAL_W       = 16;
    localparam int DIST_W      = 40;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_W       = 4;
    localparam int FEAT_DEPTH  = SRC_PIXELS * MAX_COMPONENTS;
    localparam int FEAT_ADDR_W = $clog2(FEAT_DEPTH);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_LEN  = 3'd4;

    // Input action codes
    localparam logic [1:0] ACT_FEAT  = 2'd0;
    localparam logic [1:0] ACT_MAP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        CMD_FEAT,
        CMD_MAP,
        CMD_QUERY,
        CMD_SEARCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [PIX_W-1:0]         pixel;
        logic [COMP_W-1:0]        comp;
        logic signed [VAL_W-1:0]  value;
        logic [PIX_W-1:0]         smatch;
        logic [PIX_W-1:0]         qx;
        logic [PIX_W-1:0]         qy;
    } cmd_t;

    typedef struct packed {
        logic [3:0]       radius;
        logic [CFG_W-1:0] src_cols;
        logic [CFG_W-1:0] src_rows;
        logic [CFG_W-1:0] dst_cols;
        logic [3:0]       vec_len;
    } cfg_t;

    typedef struct packed {
        logic push;
    } queue_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_MAP,
        S_MAPC,
        S_MAPW,
        S_DIV,
        S_POS,
        S_IDX,
        S_IDXC,
        S_FRD,
        S_FSQ,
        S_FACC,
        S_CMP,
        S_DONE
    } back_state_t;

endpackage

/* src/cnm_req_if.sv */
// Request channel interface: valid/ready plus the input transaction fields.
// Depends on nothing.
interface cnm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [11:0]        pixel_index;
    logic [2:0]         component;
    logic signed [15:0] value;
    logic [11:0]        source_match;
    logic [11:0]        query_x;
    logic [11:0]        query_y;
    logic               last_component;

    modport source (output valid, action, pixel_index, component, value, source_match,
                    query_x, query_y, last_component, input ready);
    modport sink (input valid, action, pixel_index, component, value, source_match,
                  query_x, query_y, last_component, output ready);
endinterface

/* src/cnm_rsp_if.sv */
// Response channel interface: valid/ready plus the result transaction fields.
// Depends on nothing.
interface cnm_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] best_index;
    logic [39:0] best_distance;

    modport source (output valid, found, best_index, best_distance, input ready);
    modport sink (input valid, found, best_index, best_distance, output ready);
endinterface

/* src/cnm_fifo.sv */
// Two-entry command queue between the front and back ends.
// Depends on cnm_pkg.
module cnm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  cnm_pkg::queue_ctl_t ctl_in,
    input  cnm_pkg::cmd_t wr_cmd,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output cnm_pkg::cmd_t rd_cmd
);
    import cnm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_cmd    = entry_reg[rd_ptr_reg];
    assign do_push   = ctl_in.push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* src/cnm_front.sv */
// Front end: accepts request transactions and classifies them into commands.
// Depends on cnm_pkg and cnm_req_if.
module cnm_front (
    cnm_req_if.sink              req,
    input  logic                 queue_full,
    output cnm_pkg::queue_ctl_t  ctl,
    output cnm_pkg::cmd_t        cmd
);
    import cnm_pkg::*;

    logic accept;

    assign req.ready = !queue_full;
    assign accept    = req.valid && !queue_full;

    // Classify the action; drop the unused code
    always_comb
    begin
        cmd.pixel  = req.pixel_index;
        cmd.comp   = req.component;
        cmd.value  = req.value;
        cmd.smatch = req.source_match;
        cmd.qx     = req.query_x;
        cmd.qy     = req.query_y;
        cmd.kind   = CMD_FEAT;
        ctl.push   = 1'b0;
        unique case (req.action)
            ACT_FEAT:
            begin
                cmd.kind = CMD_FEAT;
                ctl.push = accept;
            end
            ACT_MAP:
            begin
                cmd.kind = CMD_MAP;
                ctl.push = accept;
            end
            ACT_QUERY:
            begin
                cmd.kind = req.last_component ? CMD_SEARCH : CMD_QUERY;
                ctl.push = accept;
            end
            default:
            begin
                ctl.push = 1'b0;
            end
        endcase
    end

endmodule

/* src/cnm_div.sv */
// Restoring divider, one quotient bit per cycle, for pixel index to (col, row).
// Depends on cnm_pkg.
module cnm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cnm_pkg::PIX_W-1:0]  dividend,
    input  logic [cnm_pkg::CFG_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [cnm_pkg::PIX_W-1:0]  quot,
    output logic [cnm_pkg::PIX_W-1:0]  rem
);
    import cnm_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] quo_reg, quo_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CFG_W:0]   trial;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg[PIX_W-1:0];

    // Shift in one dividend bit and subtract when it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[PIX_W-1]};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(PIX_W);
            rem_next  = '0;
            quo_next  = dividend;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = CFG_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[PIX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CFG_W-1:0];
                quo_next = {quo_reg[PIX_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

/* src/cnm_back.sv */
// Back end: feature store, match map, query buffer and the neighbour search.
// Depends on cnm_pkg, cnm_rsp_if, cnm_div and the assertion macro header.
`include "coherence_neighbor_match_macros.svh"

module cnm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  cnm_pkg::cfg_t cfg,
    input  cnm_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    cnm_rsp_if.source     rsp
);
    import cnm_pkg::*;

    // Storage
    logic signed [VAL_W-1:0] feat_mem_reg [FEAT_DEPTH];
    logic [PIX_W-1:0]        map_mem_reg [DST_PIXELS];
    logic signed [VAL_W-1:0] qbuf_reg [MAX_COMPONENTS];
    logic signed [VAL_W-1:0] feat_q_reg;
    logic [PIX_W-1:0]        map_q_reg;

    back_state_t state_reg, state_next;
    logic [PIX_W-1:0]       x_reg, x_next, y_reg, y_next;
    logic [PIX_W-1:0]       minx_reg, minx_next;
    logic [CFG_W-1:0]       maxx_reg, maxx_next;
    logic [CFG_W-1:0]       yy_reg, yy_next, xx_reg, xx_next;
    logic signed [CFG_W:0]  lim_reg, lim_next;
    logic [2*CFG_W-1:0]     m_reg, m_next;
    logic signed [CFG_W+1:0] px_reg, px_next;
    logic [CFG_W:0]         py_reg, py_next;
    logic                   ok_reg, ok_next;
    logic [2*CFG_W:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [2*VAL_W+1:0]     sq_reg, sq_next;
    logic [DIST_W-1:0]      acc_reg, acc_next;
    logic                   have_reg, have_next;
    logic [PIX_W-1:0]       best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]      best_dist_reg, best_dist_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [PIX_W-1:0]       best_index_reg, best_index_next;
    logic [DIST_W-1:0]      best_distance_reg, best_distance_next;

    logic                   feat_we, map_we, qbuf_we;
    logic [FEAT_ADDR_W-1:0] feat_raddr;
    logic [CNT_W-1:0]       n_len;
    logic [PIX_W-1:0]       r_ext, miny_c, minx_c;
    logic [CFG_W-1:0]       xr_c, dmax_c;
    logic signed [VAL_W:0]  diff_c;
    logic signed [2*VAL_W+1:0] prod_c;
    logic [DIST_W:0]        sum_c;

    logic             div_start, div_busy, div_done;
    logic [PIX_W-1:0] div_quot, div_rem;

    cnm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (map_q_reg),
        .divisor  (cfg.src_cols),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Load ports, taken straight from the queue head while idle
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;
    assign feat_we    = cmd_pop && (cmd.kind == CMD_FEAT);
    assign map_we     = cmd_pop && (cmd.kind == CMD_MAP);
    assign qbuf_we    = cmd_pop && (cmd.kind == CMD_QUERY || cmd.kind == CMD_SEARCH);
    assign feat_raddr = {idx_reg[PIX_W-1:0], cnt_reg[COMP_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_mem_reg[{cmd.pixel, cmd.comp}] <= cmd.value;
        end
        feat_q_reg <= feat_mem_reg[feat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem_reg[cmd.pixel] <= cmd.smatch;
        end
        map_q_reg <= map_mem_reg[m_reg[PIX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (qbuf_we)
        begin
            qbuf_reg[cmd.comp] <= cmd.value;
        end
    end

    // Window bounds for a new search, the clamped vector length and the distance arithmetic
    always_comb
    begin
        r_ext  = PIX_W'(cfg.radius);
        miny_c = (cmd.qy >= r_ext) ? cmd.qy - r_ext : '0;
        minx_c = (cmd.qx >= r_ext) ? cmd.qx - r_ext : '0;
        xr_c   = {1'b0, cmd.qx} + CFG_W'(cfg.radius);
        dmax_c = cfg.dst_cols - 1'b1;
        n_len  = (cfg.vec_len > CNT_W'(MAX_COMPONENTS)) ? CNT_W'(MAX_COMPONENTS) : cfg.vec_len;
        diff_c = $signed({qbuf_reg[cnt_reg[COMP_W-1:0]][VAL_W-1],
                          qbuf_reg[cnt_reg[COMP_W-1:0]]})
               - $signed({feat_q_reg[VAL_W-1], feat_q_reg});
        prod_c = diff_c * diff_c;
        sum_c  = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
    end

    // Search sequencer
    always_comb
    begin
        state_next         = state_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        minx_next          = minx_reg;
        maxx_next          = maxx_reg;
        yy_next            = yy_reg;
        xx_next            = xx_reg;
        lim_next           = lim_reg;
        m_next             = m_reg;
        px_next            = px_reg;
        py_next            = py_reg;
        ok_next            = ok_reg;
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        sq_next            = sq_reg;
        acc_next           = acc_reg;
        have_next          = have_reg;
        best_idx_next      = best_idx_reg;
        best_dist_next     = best_dist_reg;
        found_next         = found_reg;
        best_index_next    = best_index_reg;
        best_distance_next = best_distance_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        div_start          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.kind == CMD_SEARCH)
                begin
                    x_next         = cmd.qx;
                    y_next         = cmd.qy;
                    minx_next      = minx_c;
                    maxx_next      = (xr_c < dmax_c) ? xr_c : dmax_c;
                    yy_next        = {1'b0, miny_c};
                    have_next      = 1'b0;
                    best_idx_next  = '0;
                    best_dist_next = '0;
                    if (cfg.src_cols == '0 || cfg.dst_cols == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                if (yy_reg > {1'b0, y_reg})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lim_next   = (yy_reg < {1'b0, y_reg}) ? $signed({1'b0, maxx_reg})
                               : $signed({2'b00, x_reg}) - 14'sd1;
                    xx_next    = {1'b0, minx_reg};
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                if ($signed({1'b0, xx_reg}) > lim_reg)
                begin
                    yy_next    = yy_reg + 1'b1;
                    state_next = S_ROW;
                end
                else
                begin
                    ok_next    = (xx_reg < cfg.dst_cols);
                    m_next     = (2*CFG_W)'(yy_reg[PIX_W-1:0]) * (2*CFG_W)'(cfg.dst_cols)
                               + (2*CFG_W)'(xx_reg);
                    state_next = S_MAPC;
                end
            end
            S_MAPC:
            begin
                if (ok_reg && m_reg < (2*CFG_W)'(DST_PIXELS))
                begin
                    state_next = S_MAPW;
                end
                else
                begin
                    xx_next    = xx_reg + 1'b1;
                    state_next = S_MAP;
                end
            end
            S_MAPW:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                px_next    = $signed({3'b000, div_rem}) + $signed({3'b000, x_reg})
                           - $signed({2'b00, xx_reg});
                py_next    = {2'b00, div_quot} + {2'b00, y_reg} - {1'b0, yy_reg};
                state_next = S_IDX;
            end
            S_IDX:
            begin
                ok_next    = (px_reg >= 0) && (px_reg < $signed({2'b00, cfg.src_cols}))
                          && (py_reg < {1'b0, cfg.src_rows});
                idx_next   = (2*CFG_W+1)'(py_reg) * (2*CFG_W+1)'(cfg.src_cols)
                           + (2*CFG_W+1)'(px_reg[CFG_W-1:0]);
                state_next = S_IDXC;
            end
            S_IDXC:
            begin
                if (ok_reg && idx_reg < (2*CFG_W+1)'(SRC_PIXELS))
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = S_FRD;
                end
                else
                begin
                    xx_next    = xx_reg + 1'b1;
                    state_next = S_MAP;
                end
            end
            S_FRD:
            begin
                state_next = (cnt_reg == n_len) ? S_CMP : S_FSQ;
            end
            S_FSQ:
            begin
                sq_next    = $unsigned(prod_c);
                state_next = S_FACC;
            end
            S_FACC:
            begin
                acc_next   = (sum_c > {1'b0, DIST_MAX}) ? DIST_MAX : sum_c[DIST_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_FRD;
            end
            S_CMP:
            begin
                if (!have_reg || acc_reg < best_dist_reg)
                begin
                    have_next      = 1'b1;
                    best_dist_next = acc_reg;
                    best_idx_next  = idx_reg[PIX_W-1:0];
                end
                xx_next    = xx_reg + 1'b1;
                state_next = S_MAP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next     = 1'b1;
                    found_next         = have_reg;
                    best_index_next    = have_reg ? best_idx_reg : '0;
                    best_distance_next = have_reg ? best_dist_reg : '0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg             <= x_next;
        y_reg             <= y_next;
        minx_reg          <= minx_next;
        maxx_reg          <= maxx_next;
        yy_reg            <= yy_next;
        xx_reg            <= xx_next;
        lim_reg           <= lim_next;
        m_reg             <= m_next;
        px_reg            <= px_next;
        py_reg            <= py_next;
        ok_reg            <= ok_next;
        idx_reg           <= idx_next;
        cnt_reg           <= cnt_next;
        sq_reg            <= sq_next;
        acc_reg           <= acc_next;
        best_idx_reg      <= best_idx_next;
        best_dist_reg     <= best_dist_next;
        found_reg         <= found_next;
        best_index_reg    <= best_index_next;
        best_distance_reg <= best_distance_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.best_index    = best_index_reg;
    assign rsp.best_distance = best_distance_reg;

    `CNM_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
    `CNM_ASSERT_NEXT(a_done_loads_out,
        state_reg == S_DONE && (!out_valid_reg || rsp.ready),
        out_valid_reg && state_reg == S_IDLE,
        "finished search did not reach the output register")
    `CNM_ASSERT_NOW(a_notfound_zero, out_valid_reg && !found_reg,
        best_index_reg == '0 && best_distance_reg == '0,
        "not-found result carries nonzero fields")

endmodule

/* src/coherence_neighbor_match.sv */
// Top level of the coherence neighbour match block: configuration registers,
// front end, command queue and search back end. Depends on cnm_pkg, the interfaces
// and all cnm_* modules.
//
// Feature loads, match map writes and query components pass through a two-entry
// command queue and are popped by the back end while it is idle, so they stream at
// one per cycle while no search runs. The last query component starts a search
// that stalls the queue. Each neighbour in the window goes through the map lookup
// (off-map ones are skipped there), the divider that turns the match into a column
// and row, and the position and bounds checks; an in-bounds candidate then reads,
// squares and adds each feature component and is compared (single feature memory
// port, one squared difference at a time). Each window row adds a row setup and an
// end-of-row check; each search also pops the command, ends the scan and delivers
// the result. The window holds up to radius*(2*radius+1)+radius neighbours. The
// result stays in an output register while further loads are accepted.
module coherence_neighbor_match (
    input  logic                          clk,
    input  logic                          rst_n,
    cnm_req_if.sink                       req,
    cnm_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [cnm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cnm_pkg::CFG_W-1:0]     cfg_data
);
    import cnm_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    queue_ctl_t q_ctl;
    cmd_t       front_cmd, head_cmd;
    logic       q_full, q_not_empty, q_pop;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS:   cfg_next.radius   = cfg_data[3:0];
                CFG_SRC_COLS: cfg_next.src_cols = cfg_data;
                CFG_SRC_ROWS: cfg_next.src_rows = cfg_data;
                CFG_DST_COLS: cfg_next.dst_cols = cfg_data;
                CFG_VEC_LEN:  cfg_next.vec_len  = cfg_data[3:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius   <= 4'd2;
            cfg_reg.src_cols <= CFG_W'(64);
            cfg_reg.src_rows <= CFG_W'(64);
            cfg_reg.dst_cols <= CFG_W'(64);
            cfg_reg.vec_len  <= 4'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cnm_front u_front (
        .req        (req),
        .queue_full (q_full),
        .ctl        (q_ctl),
        .cmd        (front_cmd)
    );

    cnm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (q_ctl),
        .wr_cmd    (front_cmd),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .rd_cmd    (head_cmd)
    );

    cnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (head_cmd),
        .cmd_valid (q_not_empty),
        .cmd_pop   (q_pop),
        .rsp       (rsp)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for coherence_neighbor_match: drives loads, map writes and
// queries, predicts each search result and checks it. Depends on cnm_pkg,
// cnm_req_if, cnm_rsp_if and the coherence_neighbor_match RTL.
module tb;
    import cnm_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code, ignored by the block
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        pixel;
        logic [2:0]         comp;
        logic signed [15:0] value;
        logic [11:0]        smatch;
        logic [11:0]        qx;
        logic [11:0]        qy;
        logic               last;
    } req_item_t;

    typedef struct {
        bit          found;
        logic [11:0] index;
        logic [39:0] distance;
    } match_res_t;

    // Scoreboard: predicts search results and compares delivered ones
    class match_scoreboard;
        logic signed [15:0] feat [0:FEAT_DEPTH-1];
        bit                 feat_wr [0:FEAT_DEPTH-1];
        logic [11:0]        map [0:DST_PIXELS-1];
        bit                 map_wr [0:DST_PIXELS-1];
        logic signed [15:0] qbuf [0:MAX_COMPONENTS-1];
        longint             radius, sc, sr, dc, vl;
        bit                 have;
        longint             best_i, best_d;
        match_res_t         pending [$];
        int                 miss_map [$];
        int                 miss_feat [$];
        bit                 seen [int];
        int                 errors, searches, hits;

        function new();
            radius = 2; sc = 64; sr = 64; dc = 64; vl = 8;
            errors = 0; searches = 0; hits = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
            case (idx)
                CFG_RADIUS:   radius = val & 'hF;
                CFG_SRC_COLS: sc = val & 'h1FFF;
                CFG_SRC_ROWS: sr = val & 'h1FFF;
                CFG_DST_COLS: dc = val & 'h1FFF;
                CFG_VEC_LEN:  vl = val & 'hF;
                default: ;
            endcase
        endfunction

        function longint sq_dist(longint pix);
            longint n, sum, d;
            n = vl > MAX_COMPONENTS ? MAX_COMPONENTS : vl;
            sum = 0;
            for (longint i = 0; i < n; i++)
            begin
                d = longint'(qbuf[i]) - longint'(feat[pix * MAX_COMPONENTS + i]);
                sum += d * d;
                if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
            end
            return sum;
        endfunction

        // Visit one neighbour; in planning mode only note entries not yet loaded
        function void visit(longint x, longint y, longint xx, longint yy, bit plan);
            longint m, s, px, py, idx, n, d;
            if (xx < 0 || yy < 0 || xx >= dc) return;
            m = yy * dc + xx;
            if (m >= DST_PIXELS) return;
            if (plan && !map_wr[m])
            begin
                miss_map.push_back(int'(m));
                return;
            end
            s  = map[m];
            px = s % sc + x - xx;
            py = s / sc + y - yy;
            if (px < 0 || py < 0 || px >= sc || py >= sr) return;
            idx = py * sc + px;
            if (idx >= SRC_PIXELS) return;
            if (plan)
            begin
                n = vl > MAX_COMPONENTS ? MAX_COMPONENTS : vl;
                for (longint i = 0; i < n; i++)
                    if (!feat_wr[idx * MAX_COMPONENTS + i] &&
                        !seen.exists(int'(idx * MAX_COMPONENTS + i)))
                    begin
                        seen[int'(idx * MAX_COMPONENTS + i)] = 1;
                        miss_feat.push_back(int'(idx * MAX_COMPONENTS + i));
                    end
                return;
            end
            d = sq_dist(idx);
            if (!have || d < best_d)
            begin
                have = 1; best_d = d; best_i = idx;
            end
        endfunction

        // Scan the window: earlier rows in full, then the left part of the query row
        function void scan(longint x, longint y, bit plan);
            longint min_y, min_x, max_x;
            have = 0; best_i = 0; best_d = 0;
            miss_map.delete(); miss_feat.delete(); seen.delete();
            if (sc == 0 || dc == 0) return;
            min_y = y - radius < 0 ? 0 : y - radius;
            min_x = x - radius < 0 ? 0 : x - radius;
            max_x = x + radius < dc ? x + radius : dc - 1;
            for (longint yy = min_y; yy < y; yy++)
                for (longint xx = min_x; xx <= max_x; xx++)
                    visit(x, y, xx, yy, plan);
            for (longint xx = min_x; xx < x; xx++)
                visit(x, y, xx, y, plan);
        endfunction

        function void note_input(req_item_t it);
            match_res_t r;
            case (it.action)
                ACT_FEAT:
                begin
                    feat[it.pixel * MAX_COMPONENTS + it.comp]    = it.value;
                    feat_wr[it.pixel * MAX_COMPONENTS + it.comp] = 1;
                end
                ACT_MAP:
                begin
                    map[it.pixel]    = it.smatch;
                    map_wr[it.pixel] = 1;
                end
                ACT_QUERY:
                begin
                    qbuf[it.comp] = it.value;
                    if (it.last)
                    begin
                        scan(it.qx, it.qy, 0);
                        r.found    = have;
                        r.index    = have ? best_i[11:0] : '0;
                        r.distance = have ? best_d[39:0] : '0;
                        pending.push_back(r);
                        searches++;
                        if (have) hits++;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(bit found, logic [11:0] index, logic [39:0] distance);
            match_res_t e;
            if (pending.size() == 0)
            begin
                report("result with no search outstanding");
                return;
            end
            e = pending.pop_front();
            if (found !== e.found)
                report($sformatf("found %0b, predicted %0b", found, e.found));
            if (index !== e.index)
                report($sformatf("best_index %0d, predicted %0d", index, e.index));
            if (distance !== e.distance)
                report($sformatf("best_distance %0d, predicted %0d", distance, e.distance));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int src_idle, rcv_idle;
    int items_sent, quiet_cycles;
    match_scoreboard sb;

    cnm_req_if req_ch ();
    cnm_rsp_if rsp_ch ();

    coherence_neighbor_match uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Receiver: decide ready at the falling edge, check at the rising edge
    initial
    begin
        rsp_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.found, rsp_ch.best_index, rsp_ch.best_distance);

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one transaction; called and returns at a falling edge
    task send(req_item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            req_ch.valid = 0;
            @(negedge clk);
        end
        req_ch.valid          = 1;
        req_ch.action         = it.action;
        req_ch.pixel_index    = it.pixel;
        req_ch.component      = it.comp;
        req_ch.value          = it.value;
        req_ch.source_match   = it.smatch;
        req_ch.query_x        = it.qx;
        req_ch.query_y        = it.qy;
        req_ch.last_component = it.last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_input(it);
        items_sent++;
        @(negedge clk);
        req_ch.valid = 0;
    endtask

    function req_item_t noise_item(logic [1:0] action);
        req_item_t it;
        it.action = action;
        it.pixel  = 12'($urandom);
        it.comp   = 3'($urandom);
        it.value  = 16'($urandom);
        it.smatch = 12'($urandom);
        it.qx     = 12'($urandom);
        it.qy     = 12'($urandom);
        it.last   = 1'($urandom);
        return it;
    endfunction

    function logic signed [15:0] rand_value();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Map entry that mostly follows the destination position, so neighbours agree
    function logic [11:0] map_value(int m);
        longint xx, yy, px, py, s;
        if ($urandom_range(4) == 0) return 12'($urandom);
        xx = m % sb.dc;
        yy = m / sb.dc;
        px = xx + $urandom_range(2) - 1;
        py = yy + $urandom_range(2) - 1;
        if (px >= sb.sc) px = sb.sc - 1;
        if (py >= sb.sr) py = sb.sr - 1;
        if (px < 0) px = 0;
        if (py < 0) py = 0;
        s = py * sb.sc + px;
        return s > 4095 ? 12'($urandom) : s[11:0];
    endfunction

    task config_write(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = CFG_W'(val);
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    // Wait until all searches are delivered and the command queue has drained
    task drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Full query: load whatever the search will read, then send every component
    task run_query(int x, int y);
        req_item_t it;
        int fill [$];
        int order [8];
        int n, j, t;
        sb.scan(x, y, 1);
        fill = sb.miss_map;
        foreach (fill[i])
        begin
            it = noise_item(ACT_MAP);
            it.pixel  = 12'(fill[i]);
            it.smatch = map_value(fill[i]);
            send(it);
        end
        sb.scan(x, y, 1);
        fill = sb.miss_feat;
        foreach (fill[i])
        begin
            it = noise_item(ACT_FEAT);
            it.pixel = 12'(fill[i] / MAX_COMPONENTS);
            it.comp  = 3'(fill[i] % MAX_COMPONENTS);
            it.value = rand_value();
            send(it);
        end
        n = sb.vl > MAX_COMPONENTS ? MAX_COMPONENTS : int'(sb.vl);
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            it = noise_item(ACT_QUERY);
            it.comp  = 3'(order[i]);
            it.value = rand_value();
            it.qx    = 12'(x);
            it.qy    = 12'(y);
            it.last  = (i == n - 1);
            send(it);
        end
    endtask

    task random_query();
        int x, y, ymax;
        ymax = 4096 / int'(sb.dc) + 1;
        if (ymax > 4095) ymax = 4095;
        x = $urandom_range(int'(sb.dc) + 1 > 4095 ? 4095 : int'(sb.dc) + 1);
        y = $urandom_range(ymax);
        if ($urandom_range(19) == 0)
        begin
            x = $urandom_range(4095);
            y = $urandom_range(4095);
        end
        run_query(x, y);
    endtask

    // Random traffic: mostly complete queries, the rest loads, noise and partial queries
    task random_phase(int count);
        req_item_t it;
        int stop, sel;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                random_query();
            else if (sel < 75)
                send(noise_item(ACT_FEAT));
            else if (sel < 88)
            begin
                it = noise_item(ACT_MAP);
                it.smatch = map_value(it.pixel);
                send(it);
            end
            else if (sel < 93)
                send(noise_item(ACT_NONE));
            else
            begin
                // partial query with no final component
                repeat ($urandom_range(1, 3))
                begin
                    it = noise_item(ACT_QUERY);
                    it.last = 0;
                    send(it);
                end
            end
        end
    endtask

    task setup(int r, int scols, int srows, int dcols, int vlen);
        config_write(CFG_RADIUS, r);
        config_write(CFG_SRC_COLS, scols);
        config_write(CFG_SRC_ROWS, srows);
        config_write(CFG_DST_COLS, dcols);
        config_write(CFG_VEC_LEN, vlen);
    endtask

    initial
    begin
        req_item_t it;
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 0;
        req_ch.action = ACT_FEAT;
        req_ch.pixel_index = '0;
        req_ch.component = '0;
        req_ch.value = '0;
        req_ch.source_match = '0;
        req_ch.query_x = '0;
        req_ch.query_y = '0;
        req_ch.last_component = 0;
        src_idle = 0;
        rcv_idle = 0;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: field extremes, ignored action, empty window, ties, far query
        it = noise_item(ACT_FEAT);
        it.pixel = 12'hFFF; it.comp = 3'd7; it.value = 16'sh8000;
        send(it);
        it.value = 16'sh7FFF;
        send(it);
        it = noise_item(ACT_MAP);
        it.pixel = 12'hFFF; it.smatch = 12'hFFF;
        send(it);
        it.pixel = 12'h000; it.smatch = 12'h000;
        send(it);
        send(noise_item(ACT_NONE));
        run_query(0, 0);
        // coherent neighbourhood: every neighbour points at the same candidate
        for (int yy = 3; yy <= 5; yy++)
            for (int xx = 3; xx <= 7; xx++)
            begin
                it = noise_item(ACT_MAP);
                it.pixel  = 12'(yy * 64 + xx);
                it.smatch = 12'(yy * 64 + xx);
                send(it);
            end
        run_query(5, 5);
        run_query(4095, 4095);
        run_query(63, 1);
        drain();

        // Several register settings, each under one of the three idling profiles
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 3)
                0: begin src_idle = 10; rcv_idle = 83; end
                1: begin src_idle = 83; rcv_idle = 10; end
                default: begin src_idle = 0; rcv_idle = 0; end
            endcase
            case (ph)
                0: setup(2, 64, 64, 64, 8);
                1: setup(0, 1, 1, 1, 1);
                2: setup(15, 4096, 1, 4096, 8);
                3: setup(3, 1, 4096, 1, 5);
                4: setup(5, 37, 50, 23, 3);
                5: setup(1, 4096, 4096, 16, 8);
                6: setup(6, 64, 64, 32, 8);
                default: setup(2, 64, 64, 64, 8);
            endcase
            case (ph)
                1: random_phase(60);
                2: random_phase(40);
                6: random_phase(25);
                default: random_phase(200);
            endcase
            drain();
        end

        $display("Covered %0d transactions and %0d searches, %0d of them with a candidate,",
                 items_sent, sb.searches, sb.hits);
        $display("over eight register settings and three handshake idling profiles.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
